[hdl/pdq_pkg.sv]
package pdq_pkg;

	localparam int NUM_LANES = 6;
	localparam int SAMPLE_W  = 28;
	localparam int MIX_W     = 31;
	localparam int WORD_W    = 24;
	localparam int GAIN_W    = 24;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [MIX_W-1:0]    mix_t;
	typedef logic [WORD_W-1:0]          word_t;

	typedef enum logic [2:0] {
		MIX_ZERO,
		MIX_MONO,
		MIX_PASS,
		MIX_REMAP,
		MIX_STEREO,
		MIX_QUAD
	} mix_kind_t;

	typedef enum logic [1:0] {
		BITS_8,
		BITS_16,
		BITS_24
	} bits_t;

	// config register indexes
	typedef enum logic [2:0] {
		REG_SRC_CH   = 3'd0,
		REG_OUT_CH   = 3'd1,
		REG_MODE     = 3'd2,
		REG_CENTER   = 3'd3,
		REG_GAIN     = 3'd4,
		REG_BITS     = 3'd5
	} reg_index_t;

	localparam logic [2:0] MODE_REMAP    = 3'd1;
	localparam logic [2:0] MODE_WEIGHTED = 3'd4;

	typedef struct packed {
		mix_kind_t  kind;
		logic       weighted;
		logic       center_order;
		logic [2:0] n;
	} mix_ctrl_t;

	typedef struct packed {
		logic [GAIN_W-1:0] gain;
		bits_t             bits;
	} quant_ctrl_t;

	typedef struct packed {
		word_t word;
		logic  clamped;
	} lane_out_t;

endpackage

[hdl/pdq_if.sv]
interface pdq_frame_if;
	import pdq_pkg::*;
	logic    valid;
	logic    ready;
	sample_t src_sample_0;
	sample_t src_sample_1;
	sample_t src_sample_2;
	sample_t src_sample_3;
	sample_t src_sample_4;
	sample_t src_sample_5;

	modport source (output valid, src_sample_0, src_sample_1, src_sample_2,
		src_sample_3, src_sample_4, src_sample_5, input ready);
	modport sink (input valid, src_sample_0, src_sample_1, src_sample_2,
		src_sample_3, src_sample_4, src_sample_5, output ready);
endinterface

interface pdq_result_if;
	import pdq_pkg::*;
	logic       valid;
	logic       ready;
	word_t      out_word;
	logic [2:0] out_channel;
	logic       clamped;
	logic       last;

	modport source (output valid, out_word, out_channel, clamped, last, input ready);
	modport sink (input valid, out_word, out_channel, clamped, last, output ready);
endinterface

[hdl/pdq_mixer.sv]
module pdq_mixer
	import pdq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  logic      in_valid,
	input  sample_t   samples [NUM_LANES],
	input  mix_ctrl_t ctrl,
	output logic      out_valid,
	output mix_t      mix [NUM_LANES]
);

	localparam logic signed [17:0] K_UP   = 18'sd77890;
	localparam logic signed [17:0] K_DOWN = 18'sd55142;
	localparam logic signed [16:0] K_0707 = 17'sd46334;

	// floor(2^32 / n); n = 1 bypasses the divider
	function automatic logic [31:0] recip(input logic [2:0] n);
		case (n)
			3'd2:    recip = 32'd2147483648;
			3'd3:    recip = 32'd1431655765;
			3'd4:    recip = 32'd1073741824;
			3'd5:    recip = 32'd858993459;
			3'd6:    recip = 32'd715827882;
			default: recip = 32'd0;
		endcase
	endfunction

	logic v_s1, v_s2, v_s3, v_s4;

	// stage 1: channel pick, surround products, mono sum
	sample_t              smp_s1 [NUM_LANES];
	sample_t              fl_s1, fr_s1, c_s1;
	logic signed [45:0]   t3l_s1, t4l_s1, t3r_s1, t4r_s1;
	logic [29:0]          abs_s1;
	logic                 neg_s1;

	logic signed [30:0]   sum_c;
	logic [30:0]          abs_c;

	always_comb begin
		sum_c = '0;
		for (int i = 0; i < NUM_LANES; i++) begin
			if (3'(i) < ctrl.n)
				sum_c = sum_c + 31'(samples[i]);
		end
		abs_c = sum_c[30] ? 31'(-sum_c) : 31'(sum_c);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NUM_LANES; i++)
				smp_s1[i] <= samples[i];
			fl_s1 <= samples[0];
			fr_s1 <= ctrl.center_order ? samples[1] : samples[2];
			c_s1  <= ctrl.center_order ? samples[2] : samples[1];
			if (ctrl.weighted) begin
				t3l_s1 <= samples[3] * K_UP;
				t4l_s1 <= samples[4] * K_DOWN;
				t3r_s1 <= samples[3] * K_DOWN;
				t4r_s1 <= samples[4] * K_UP;
			end else begin
				t3l_s1 <= 46'($signed({samples[3], 16'b0}));
				t4l_s1 <= 46'($signed({samples[4], 16'b0}));
				t3r_s1 <= 46'($signed({samples[3], 16'b0}));
				t4r_s1 <= 46'($signed({samples[4], 16'b0}));
			end
			abs_s1 <= abs_c[29:0];
			neg_s1 <= sum_c[30];
		end
	end

	// stage 2: Q.40 inner sums, reciprocal multiply
	sample_t             smp_s2 [NUM_LANES];
	sample_t             fl_s2, fr_s2;
	logic signed [47:0]  inl_s2, inr_s2;
	logic [29:0]         abs_s2, est_s2;
	logic                neg_s2;

	logic signed [47:0]  cs_c, s5_c, quad_c;
	logic [61:0]         rprod_c;

	always_comb begin
		cs_c    = 48'($signed({c_s1, 16'b0}));
		s5_c    = 48'($signed({smp_s1[5], 16'b0}));
		quad_c  = cs_c + s5_c;
		rprod_c = abs_s1 * recip(ctrl.n);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NUM_LANES; i++)
				smp_s2[i] <= smp_s1[i];
			fl_s2 <= fl_s1;
			fr_s2 <= fr_s1;
			if (ctrl.kind == MIX_STEREO) begin
				inl_s2 <= cs_c - 48'(t3l_s1) - 48'(t4l_s1) + s5_c;
				inr_s2 <= cs_c + 48'(t3r_s1) + 48'(t4r_s1) + s5_c;
			end else begin
				inl_s2 <= quad_c;
				inr_s2 <= quad_c;
			end
			abs_s2 <= abs_s1;
			est_s2 <= rprod_c[61:32];
			neg_s2 <= neg_s1;
		end
	end

	// stage 3: 0.707 weight, quotient correction
	sample_t             smp_s3 [NUM_LANES];
	sample_t             fl_s3, fr_s3;
	logic signed [64:0]  pl_s3, pr_s3;
	logic [29:0]         q_s3;
	logic                neg_s3;

	logic [33:0]         next_c;

	always_comb begin
		next_c = (34'(est_s2) + 34'd1) * 34'(ctrl.n);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NUM_LANES; i++)
				smp_s3[i] <= smp_s2[i];
			fl_s3 <= fl_s2;
			fr_s3 <= fr_s2;
			pl_s3 <= inl_s2 * K_0707;
			pr_s3 <= inr_s2 * K_0707;
			if (ctrl.n == 3'd1)
				q_s3 <= abs_s2;
			else if (34'(abs_s2) >= next_c)
				q_s3 <= est_s2 + 30'd1;
			else
				q_s3 <= est_s2;
			neg_s3 <= neg_s2;
		end
	end

	// stage 4: base add, output selection
	mix_t                ml_c, mr_c, mean_c;
	mix_t                sel_c [NUM_LANES];
	logic signed [32:0]  sl_c, sr_c;

	always_comb begin
		sl_c   = 33'(fl_s3) + pl_s3[64:32];
		sr_c   = 33'(fr_s3) + pr_s3[64:32];
		ml_c   = sl_c[MIX_W-1:0];
		mr_c   = sr_c[MIX_W-1:0];
		mean_c = neg_s3 ? -mix_t'({1'b0, q_s3}) : mix_t'({1'b0, q_s3});
		for (int i = 0; i < NUM_LANES; i++)
			sel_c[i] = '0;
		case (ctrl.kind)
			MIX_MONO: begin
				sel_c[0] = mean_c;
			end
			MIX_PASS: begin
				for (int i = 0; i < NUM_LANES; i++)
					sel_c[i] = MIX_W'(smp_s3[i]);
			end
			MIX_REMAP: begin
				sel_c[0] = MIX_W'(fl_s3);
				sel_c[1] = MIX_W'(fr_s3);
				sel_c[2] = MIX_W'(ctrl.center_order ? smp_s3[2] : smp_s3[1]);
				sel_c[3] = MIX_W'(smp_s3[5]);
				sel_c[4] = MIX_W'(smp_s3[3]);
				sel_c[5] = MIX_W'(smp_s3[4]);
			end
			MIX_STEREO: begin
				sel_c[0] = ml_c;
				sel_c[1] = mr_c;
			end
			MIX_QUAD: begin
				sel_c[0] = ml_c;
				sel_c[1] = mr_c;
				sel_c[2] = MIX_W'(smp_s3[3]);
				sel_c[3] = MIX_W'(smp_s3[4]);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NUM_LANES; i++)
				mix[i] <= sel_c[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	assign out_valid = v_s4;

endmodule

[hdl/pdq_quant_lane.sv]
module pdq_quant_lane
	import pdq_pkg::*;
(
	input  logic        clk,
	input  logic        en,
	input  mix_t        mix,
	input  quant_ctrl_t ctrl,
	output lane_out_t   result
);

	logic signed [55:0] p_s1;

	always_ff @(posedge clk) begin
		if (en)
			p_s1 <= mix * $signed({1'b0, ctrl.gain});
	end

	logic        neg, big, clip;
	logic [55:0] mag;
	logic [63:0] m64, t;
	word_t       fs, maxneg, q;
	logic [24:0] val;
	word_t       word;

	// mag * fs computed as (mag << (b-1)) - mag
	always_comb begin
		neg = p_s1[55];
		mag = neg ? 56'(-p_s1) : 56'(p_s1);
		big = |mag[55:41];
		m64 = 64'(mag[40:0]);
		case (ctrl.bits)
			BITS_8: begin
				t      = (m64 << 7) - m64;
				fs     = 24'd127;
				maxneg = 24'd128;
			end
			BITS_24: begin
				t      = (m64 << 23) - m64;
				fs     = 24'd8388607;
				maxneg = 24'd8388608;
			end
			default: begin
				t      = (m64 << 15) - m64;
				fs     = 24'd32767;
				maxneg = 24'd32768;
			end
		endcase
		q    = t[63:40];
		clip = 1'b0;
		if (big) begin
			clip = 1'b1;
			q    = neg ? maxneg : fs;
		end else if (neg && q > maxneg) begin
			clip = 1'b1;
			q    = maxneg;
		end else if (!neg && q > fs) begin
			clip = 1'b1;
			q    = fs;
		end
		val = neg ? -{1'b0, q} : {1'b0, q};
		case (ctrl.bits)
			BITS_8:  word = {16'b0, val[7:0] + 8'h80};
			BITS_24: word = val[23:0];
			default: word = {8'b0, val[15:0]};
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			result.word    <= word;
			result.clamped <= clip;
		end
	end

endmodule

[hdl/pdq_serializer.sv]
module pdq_serializer
	import pdq_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       ld_valid,
	output logic       ld_ready,
	input  lane_out_t  lanes [NUM_LANES],
	input  logic [2:0] m,
	input  logic       m_ok,
	pdq_result_if.source result
);

	lane_out_t  buf_q [NUM_LANES];
	logic [2:0] cnt_q;
	logic       busy_q;
	logic       last, out_fire, ld_fire;

	assign last     = cnt_q == m - 3'd1;
	assign out_fire = busy_q && result.ready;
	assign ld_ready = !busy_q || (out_fire && last);
	assign ld_fire  = ld_valid && ld_ready;

	always_ff @(posedge clk) begin
		if (ld_fire) begin
			for (int i = 0; i < NUM_LANES; i++)
				buf_q[i] <= lanes[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (ld_fire && m_ok) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (out_fire && last) begin
			busy_q <= 1'b0;
		end else if (out_fire) begin
			cnt_q <= cnt_q + 3'd1;
		end
	end

	assign result.valid       = busy_q;
	assign result.out_word    = buf_q[cnt_q].word;
	assign result.out_channel = cnt_q;
	assign result.clamped     = buf_q[cnt_q].clamped;
	assign result.last        = last;

	a_next_channel: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.ready && !result.last |=>
			result.valid && result.out_channel == $past(result.out_channel) + 3'd1)
		else $error("channel index did not advance within a frame");

	a_frame_start: assert property (@(posedge clk) disable iff (!arst_n)
		ld_valid && ld_ready && m_ok |=> result.valid && result.out_channel == 3'd0)
		else $error("new frame does not start at channel zero");

	a_drop_frame: assert property (@(posedge clk) disable iff (!arst_n)
		ld_valid && ld_ready && !m_ok |=> !result.valid)
		else $error("frame with no output channels produced a transfer");

endmodule

[hdl/pcm_downmix_quantizer_top.sv]
// Surround downmix and PCM quantizer.
// frame  (sink):   one transfer carries six signed Q4.24 source samples.
// result (source): one transfer per output channel: the quantized word,
//   its channel index, a clip flag and a last flag on the final channel.
// Config: wr_en/wr_index/wr_data write one register per cycle; change it
//   only while no frame is in flight.
// Pipeline: a frame passes 4 mixer stages, 2 quantizer stages and the
//   serializer load before its first word shows on the result port.
// Throughput: the single result port emits one word per cycle while
//   result.ready is high; a frame holds it until its last word is out,
//   and the next frame loads as that word leaves, so frames are taken one
//   per cycle when m, the output channel count, is 1.
// A frame whose output count is out of range is accepted and yields no
//   transfer.
// Stall: when result.ready is low the serializer holds its word and the
//   pipeline freezes once its last quantizer stage is full; frame.ready then
//   drops. Every stage holds while frozen, bubbles included.
// Reset: arst_n clears all valid state and returns the registers to
//   2 in / 2 out, mode 0, L C R order, unity gain, 16-bit words.
module pcm_downmix_quantizer_top
	import pdq_pkg::*;
#(
	parameter int MAX_CHANNELS = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [2:0]  wr_index,
	input  logic [23:0] wr_data,
	pdq_frame_if.sink    frame,
	pdq_result_if.source result
);

	// largest legal channel count
	localparam int         LIM_I = (MAX_CHANNELS < NUM_LANES) ? MAX_CHANNELS : NUM_LANES;
	localparam logic [2:0] LIM   = 3'(LIM_I);

	// configuration registers
	logic [2:0]  src_ch_q, out_ch_q, mode_q;
	logic        center_q;
	logic [23:0] gain_q;
	logic [4:0]  bits_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_ch_q <= 3'd2;
			out_ch_q <= 3'd2;
			mode_q   <= 3'd0;
			center_q <= 1'b0;
			gain_q   <= 24'd65536;
			bits_q   <= 5'd16;
		end else if (wr_en) begin
			case (wr_index)
				REG_SRC_CH: src_ch_q <= wr_data[2:0];
				REG_OUT_CH: out_ch_q <= wr_data[2:0];
				REG_MODE:   mode_q   <= wr_data[2:0];
				REG_CENTER: center_q <= wr_data[0];
				REG_GAIN:   gain_q   <= wr_data;
				REG_BITS:   bits_q   <= wr_data[4:0];
				default: begin
				end
			endcase
		end
	end

	// decode of the channel pairing
	logic        src_ok, m_ok;
	mix_ctrl_t   mctrl;
	quant_ctrl_t qctrl;

	always_comb begin
		src_ok = src_ch_q >= 3'd1 && src_ch_q <= LIM;
		m_ok   = out_ch_q >= 3'd1 && out_ch_q <= LIM;
		mctrl.weighted     = mode_q == MODE_WEIGHTED;
		mctrl.center_order = center_q;
		mctrl.n            = src_ch_q;
		if (out_ch_q == 3'd1)
			mctrl.kind = src_ok ? MIX_MONO : MIX_ZERO;
		else if (out_ch_q == src_ch_q && !(out_ch_q == 3'd6 && mode_q == MODE_REMAP))
			mctrl.kind = MIX_PASS;
		else if (src_ch_q == 3'd6 && src_ok) begin
			case (out_ch_q)
				3'd6:    mctrl.kind = MIX_REMAP;
				3'd2:    mctrl.kind = MIX_STEREO;
				3'd4:    mctrl.kind = MIX_QUAD;
				default: mctrl.kind = MIX_ZERO;
			endcase
		end else
			mctrl.kind = MIX_ZERO;
		qctrl.gain = gain_q;
		case (bits_q)
			5'd8:    qctrl.bits = BITS_8;
			5'd24:   qctrl.bits = BITS_24;
			default: qctrl.bits = BITS_16;
		endcase
	end

	// pipeline advance: all stages move together unless the last
	// quantizer stage is full and the serializer cannot take it
	logic en, vq_s1, vq_s2, ld_ready;

	assign en          = !vq_s2 || ld_ready;
	assign frame.ready = en;

	sample_t samples [NUM_LANES];
	assign samples[0] = frame.src_sample_0;
	assign samples[1] = frame.src_sample_1;
	assign samples[2] = frame.src_sample_2;
	assign samples[3] = frame.src_sample_3;
	assign samples[4] = frame.src_sample_4;
	assign samples[5] = frame.src_sample_5;

	logic mix_valid;
	mix_t mix [NUM_LANES];

	pdq_mixer u_mixer (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (frame.valid),
		.samples   (samples),
		.ctrl      (mctrl),
		.out_valid (mix_valid),
		.mix       (mix)
	);

	// one quantizer per output channel
	lane_out_t lanes [NUM_LANES];

	for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
		pdq_quant_lane u_lane (
			.clk    (clk),
			.en     (en),
			.mix    (mix[g]),
			.ctrl   (qctrl),
			.result (lanes[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vq_s1 <= 1'b0;
			vq_s2 <= 1'b0;
		end else if (en) begin
			vq_s1 <= mix_valid;
			vq_s2 <= vq_s1;
		end
	end

	// merge: lanes are loaded as one frame and leave one word per transfer
	pdq_serializer u_ser (
		.clk      (clk),
		.arst_n   (arst_n),
		.ld_valid (vq_s2),
		.ld_ready (ld_ready),
		.lanes    (lanes),
		.m        (out_ch_q),
		.m_ok     (m_ok),
		.result   (result)
	);

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!vq_s2 && !result.valid |-> frame.ready)
		else $error("input stalled with an empty pipeline tail");

	a_last_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		vq_s2 && !ld_ready |=> vq_s2)
		else $error("stalled frame lost at quantizer output");

	a_lane_count: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> result.out_channel < LIM || result.out_channel == LIM)
		else $error("channel index beyond the lane count");

endmodule

[dv/pcm_downmix_quantizer_top_tb.sv]
`timescale 1ns / 100ps

module pcm_downmix_quantizer_top_tb;
	import pdq_pkg::*;

	// block parameter, also the widest legal output count
	localparam int MAX_CH = 6;

	// Mix coefficients, Q1.16
	localparam longint SCALE_0707 = 46334;
	localparam longint LEVEL_UP   = 77890;   // +1.5 dB
	localparam longint LEVEL_DOWN = 55142;   // -1.5 dB
	localparam longint UNITY      = 65536;
	localparam longint OFFSET_8   = 128;     // unsigned 8-bit PCM midpoint

	localparam logic [2:0] MODE_PLAIN = 3'd0;
	localparam logic [2:0] MODE_OTHER = 3'd2;
	localparam logic [2:0] MODE_TOP   = 3'd7;
	localparam logic [2:0] REG_SPARE  = 3'd7;   // past the register list, must be ignored

	localparam logic [4:0] WORD_8  = 5'd8;
	localparam logic [4:0] WORD_16 = 5'd16;
	localparam logic [4:0] WORD_24 = 5'd24;
	localparam logic [4:0] WORD_ODD = 5'd31;

	localparam logic [23:0] UNITY_GAIN = 24'h010000;
	localparam logic [23:0] FULL_GAIN  = 24'hFFFFFF;

	localparam sample_t S_MAX  = 28'sh7FFFFFF;
	localparam sample_t S_MIN  = -28'sd134217728;
	localparam sample_t S_ONE  = 28'sd16777216;
	localparam sample_t S_NEG1 = -28'sd16777216;
	localparam sample_t S_ZERO = 28'sd0;

	localparam int NUM_ROWS      = 25;
	localparam int RANDOM_FRAMES = 445;
	localparam int SETTLE_CYCLES = 16;      // pipeline is 7 deep, leave margin
	localparam int LIMIT_CYCLES  = 400000;

	typedef sample_t [0:NUM_LANES-1] lanes_t;

	typedef struct packed {
		word_t      word;
		logic [2:0] chan;
		logic       clamped;
		logic       last;
	} word_result_t;

	// One directed frame: optional register load, the six samples, and an
	// optional hand-typed word/clamp that every channel of the frame must show.
	typedef struct packed {
		logic        load;
		logic [2:0]  src;
		logic [2:0]  out;
		logic [2:0]  mode;
		logic        center;
		logic [23:0] gain;
		logic [4:0]  bits;
		lanes_t      lanes;
		logic        typed;
		word_t       t_word;
		logic        t_clamp;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic wr_en;
	logic [2:0] wr_index;
	logic [23:0] wr_data;

	pdq_frame_if  frame_ch();
	pdq_result_if result_ch();

	pcm_downmix_quantizer_top #(
		.MAX_CHANNELS(MAX_CH)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.frame    (frame_ch),
		.result   (result_ch)
	);

	// Register shadow, follows every write the bench issues
	logic [2:0]  cfg_src;
	logic [2:0]  cfg_out;
	logic [2:0]  cfg_mode;
	logic        cfg_center;
	logic [23:0] cfg_gain;
	logic [4:0]  cfg_bits;

	word_result_t pending_words[$];   // words owed by the block, oldest first
	word_result_t got_word;
	logic         failed = 1'b0;
	logic         no_stall = 1'b0;   // quiet stretch: neither side idles
	int           cycle_count = 0;
	dir_row_t     directed_rows [0:NUM_ROWS-1];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// base + 0.707 * inner, inner at Q.40; arithmetic shift floors
	function automatic longint add_center_weight(input longint base, input longint inner);
		return base + ((inner * SCALE_0707) >>> 32);
	endfunction

	// Mix one frame under the shadow registers and quantize each output
	// channel. Returns how many words the frame should produce.
	function automatic int mix_and_quantize(input lanes_t lanes,
			output word_result_t words [NUM_LANES]);
		longint s [NUM_LANES];
		longint mix [NUM_LANES];
		longint sum, fl, fr, ctr, w_l3, w_l4, w_r3, w_r4, p, val;
		longint unsigned fs, maxneg, mag, q;
		int n, m, bits, i;
		logic neg, clip;
		n = int'(cfg_src);
		m = int'(cfg_out);
		for (i = 0; i < NUM_LANES; i++) begin
			words[i] = '0;
		end
		if (m < 1 || m > MAX_CH)
			return 0;
		for (i = 0; i < NUM_LANES; i++) begin
			s[i] = longint'(sample_t'(lanes[i]));
			mix[i] = 0;
		end

		if (m == 1) begin
			// mean, truncated toward zero; nothing when the source count is bad
			if (n >= 1 && n <= MAX_CH) begin
				sum = 0;
				for (i = 0; i < n; i++)
					sum += s[i];
				mix[0] = sum / longint'(n);
			end
		end else if (m == n && !(m == 6 && cfg_mode == MODE_REMAP)) begin
			for (i = 0; i < m; i++)
				mix[i] = s[i];
		end else if (n == 6) begin
			fl = s[0];
			fr = cfg_center ? s[1] : s[2];
			ctr = cfg_center ? s[2] : s[1];
			if (m == 6) begin
				mix[0] = fl;
				mix[1] = fr;
				mix[2] = ctr;
				mix[3] = s[5];
				mix[4] = s[3];
				mix[5] = s[4];
			end else if (m == 2) begin
				w_l3 = UNITY;
				w_l4 = UNITY;
				w_r3 = UNITY;
				w_r4 = UNITY;
				if (cfg_mode == MODE_WEIGHTED) begin
					w_l3 = LEVEL_UP;
					w_l4 = LEVEL_DOWN;
					w_r3 = LEVEL_DOWN;
					w_r4 = LEVEL_UP;
				end
				mix[0] = add_center_weight(fl,
					ctr * UNITY - w_l3 * s[3] - w_l4 * s[4] + s[5] * UNITY);
				mix[1] = add_center_weight(fr,
					ctr * UNITY + w_r3 * s[3] + w_r4 * s[4] + s[5] * UNITY);
			end else if (m == 4) begin
				mix[0] = add_center_weight(fl, (ctr + s[5]) * UNITY);
				mix[1] = add_center_weight(fr, (ctr + s[5]) * UNITY);
				mix[2] = s[3];
				mix[3] = s[4];
			end
		end

		bits = (cfg_bits == WORD_8 || cfg_bits == WORD_24) ? int'(cfg_bits) : 16;
		fs = (64'd1 << (bits - 1)) - 1;
		maxneg = 64'd1 << (bits - 1);
		for (i = 0; i < m; i++) begin
			p = mix[i] * longint'({40'd0, cfg_gain});
			neg = p < 0;
			mag = neg ? -p : p;
			clip = 1'b0;
			if (mag >= (64'd1 << 41)) begin
				clip = 1'b1;
				q = neg ? maxneg : fs;
			end else begin
				q = (mag * fs) >> 40;
				if (neg && q > maxneg) begin
					q = maxneg;
					clip = 1'b1;
				end
				if (!neg && q > fs) begin
					q = fs;
					clip = 1'b1;
				end
			end
			val = neg ? -longint'(q) : longint'(q);
			if (bits == 8)
				val += OFFSET_8;
			words[i].word = word_t'(val & ((64'd1 << bits) - 1));
			words[i].chan = 3'(i);
			words[i].clamped = clip;
			words[i].last = (i + 1 == m);
		end
		return m;
	endfunction

	task automatic write_reg(input logic [2:0] idx, input logic [23:0] data);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		@(posedge clk);
	endtask

	// Write every register; unused upper data bits carry noise, which the
	// block must drop. A write past the list closes the batch.
	task automatic load_config(input logic [2:0] src, input logic [2:0] out,
			input logic [2:0] mode, input logic center, input logic [23:0] gain,
			input logic [4:0] bits);
		logic [23:0] noise;
		noise = 24'($urandom);
		write_reg(REG_SRC_CH, {noise[23:3], src});
		write_reg(REG_OUT_CH, {noise[23:3], out});
		write_reg(REG_MODE, {noise[23:3], mode});
		write_reg(REG_CENTER, {noise[23:1], center});
		write_reg(REG_GAIN, gain);
		write_reg(REG_BITS, {noise[23:5], bits});
		write_reg(REG_SPARE, noise);
		wr_en <= 1'b0;
		cfg_src = src;
		cfg_out = out;
		cfg_mode = mode;
		cfg_center = center;
		cfg_gain = gain;
		cfg_bits = bits;
	endtask

	// Offer one frame, optionally after an idle gap, and hold it until the
	// transfer. valid stays high afterwards; the caller lowers it.
	task automatic send_frame(input lanes_t lanes, input logic typed,
			input word_t t_word, input logic t_clamp);
		word_result_t words [NUM_LANES];
		int cnt, i;
		if (!no_stall && $urandom_range(0, 99) < 33) begin
			frame_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		frame_ch.valid <= 1'b1;
		frame_ch.src_sample_0 <= lanes[0];
		frame_ch.src_sample_1 <= lanes[1];
		frame_ch.src_sample_2 <= lanes[2];
		frame_ch.src_sample_3 <= lanes[3];
		frame_ch.src_sample_4 <= lanes[4];
		frame_ch.src_sample_5 <= lanes[5];
		do
			@(posedge clk);
		while (!frame_ch.ready);
		cnt = mix_and_quantize(lanes, words);
		for (i = 0; i < cnt; i++) begin
			if (typed) begin
				words[i].word = t_word;
				words[i].clamped = t_clamp;
			end
			pending_words.push_back(words[i]);
		end
	endtask

	// Block is idle once every owed word is out and frames that owe
	// nothing have had time to drain.
	task automatic wait_idle();
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic sample_t pick_sample();
		case ($urandom_range(0, 9))
			0: return S_MAX;
			1: return S_MIN;
			2, 3, 4: return sample_t'($urandom);
			default: return sample_t'(int'($urandom_range(0, 33554432)) - 16777216);
		endcase
	endfunction

	// Result side: ready drops about a third of the time outside the quiet stretch
	always @(posedge clk) begin
		result_ch.ready <= arst_n && (no_stall || ($urandom_range(0, 99) >= 33));
	end

	// Check each result transfer against the oldest owed word
	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_words.size() == 0) begin
				$error("unexpected transfer: out_channel %0d out_word %h",
					result_ch.out_channel, result_ch.out_word);
				failed = 1'b1;
			end else begin
				got_word = pending_words.pop_front();
				if (result_ch.out_word !== got_word.word) begin
					$error("out_word: expected %h, got %h", got_word.word, result_ch.out_word);
					failed = 1'b1;
				end
				if (result_ch.out_channel !== got_word.chan) begin
					$error("out_channel: expected %0d, got %0d", got_word.chan,
						result_ch.out_channel);
					failed = 1'b1;
				end
				if (result_ch.clamped !== got_word.clamped) begin
					$error("clamped: expected %b, got %b", got_word.clamped, result_ch.clamped);
					failed = 1'b1;
				end
				if (result_ch.last !== got_word.last) begin
					$error("last: expected %b, got %b", got_word.last, result_ch.last);
					failed = 1'b1;
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin
		int row, sent, burst, k;
		logic [2:0] src, out, mode;
		logic center;
		logic [23:0] gain;
		logic [4:0] bits;
		lanes_t lanes;

		// Directed frames. Rows with typed = 1 carry the word and clamp flag
		// every channel must show; the others lean on the predictor.
		directed_rows = '{
			// reset settings: 2 in, 2 out, unity gain, 16-bit
			'{0, 2, 2, MODE_PLAIN, 0, UNITY_GAIN, WORD_16,
				'{S_ONE, S_ONE, S_ZERO, S_ZERO, S_ZERO, S_ZERO}, 1, 24'h007FFF, 0},
			'{0, 2, 2, MODE_PLAIN, 0, UNITY_GAIN, WORD_16,
				'{S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX}, 1, 24'h007FFF, 1},
			'{0, 2, 2, MODE_PLAIN, 0, UNITY_GAIN, WORD_16,
				'{S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN}, 1, 24'h008000, 1},
			// -1.0 lands one step above the negative limit, no clip
			'{0, 2, 2, MODE_PLAIN, 0, UNITY_GAIN, WORD_16,
				'{S_NEG1, S_NEG1, S_ZERO, S_ZERO, S_ZERO, S_ZERO}, 1, 24'h008001, 0},
			// 8-bit words carry the midpoint offset
			'{1, 2, 2, MODE_PLAIN, 0, UNITY_GAIN, WORD_8,
				'{S_ZERO, S_ZERO, S_ZERO, S_ZERO, S_ZERO, S_ZERO}, 1, 24'h000080, 0},
			'{1, 2, 2, MODE_PLAIN, 0, UNITY_GAIN, WORD_8,
				'{S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX}, 1, 24'h0000FF, 1},
			'{1, 2, 2, MODE_PLAIN, 0, UNITY_GAIN, WORD_8,
				'{S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN}, 1, 24'h000000, 1},
			'{1, 2, 2, MODE_PLAIN, 0, UNITY_GAIN, WORD_24,
				'{S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX}, 1, 24'h7FFFFF, 1},
			'{1, 2, 2, MODE_PLAIN, 0, UNITY_GAIN, WORD_24,
				'{S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN}, 1, 24'h800000, 1},
			// odd word sizes act as 16-bit
			'{1, 2, 2, MODE_PLAIN, 0, UNITY_GAIN, WORD_ODD,
				'{S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX}, 1, 24'h007FFF, 1},
			'{1, 2, 2, MODE_PLAIN, 1, 24'h000000, 5'd0,
				'{S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX}, 1, 24'h000000, 0},
			// unsupported pairings and bad source counts mix to zero
			'{1, 3, 5, MODE_PLAIN, 0, UNITY_GAIN, WORD_8,
				'{S_MAX, S_MIN, S_MAX, S_MIN, S_MAX, S_MIN}, 1, 24'h000080, 0},
			'{1, 0, 1, MODE_PLAIN, 0, UNITY_GAIN, WORD_8,
				'{S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX}, 1, 24'h000080, 0},
			'{1, 7, 1, MODE_PLAIN, 0, UNITY_GAIN, WORD_8,
				'{S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX}, 1, 24'h000080, 0},
			'{1, 6, 3, MODE_OTHER, 1, UNITY_GAIN, WORD_8,
				'{S_MAX, S_MIN, S_MAX, S_MIN, S_MAX, S_MIN}, 1, 24'h000080, 0},
			// output count of zero: frame taken, nothing comes out
			'{1, 2, 0, MODE_PLAIN, 0, UNITY_GAIN, WORD_16,
				'{S_ONE, S_ONE, S_ZERO, S_ZERO, S_ZERO, S_ZERO}, 0, 24'h000000, 0},
			// mono of six with a small negative sum: divide truncates toward zero
			'{1, 6, 1, MODE_PLAIN, 0, FULL_GAIN, WORD_24,
				'{-28'sd1, -28'sd1, -28'sd1, -28'sd1, -28'sd1, S_ZERO}, 0, 24'h000000, 0},
			'{1, 6, 6, MODE_PLAIN, 0, UNITY_GAIN, WORD_24,
				'{28'sd3000000, -28'sd5000000, 28'sd12345678, -28'sd777777,
				28'sd20000000, -28'sd16777216}, 0, 24'h000000, 0},
			// six-to-six remap, both center orders
			'{1, 6, 6, MODE_REMAP, 0, UNITY_GAIN, WORD_24,
				'{28'sd3000000, -28'sd5000000, 28'sd12345678, -28'sd777777,
				28'sd20000000, -28'sd16777216}, 0, 24'h000000, 0},
			'{1, 6, 6, MODE_REMAP, 1, UNITY_GAIN, WORD_24,
				'{28'sd3000000, -28'sd5000000, 28'sd12345678, -28'sd777777,
				28'sd20000000, -28'sd16777216}, 0, 24'h000000, 0},
			// stereo downmix, plain and weighted surrounds, then a quad downmix
			'{1, 6, 2, MODE_PLAIN, 0, UNITY_GAIN, WORD_24,
				'{28'sd3000000, -28'sd5000000, 28'sd12345678, -28'sd777777,
				28'sd2000000, -28'sd1677721}, 0, 24'h000000, 0},
			'{1, 6, 2, MODE_WEIGHTED, 1, UNITY_GAIN, WORD_24,
				'{28'sd3000000, -28'sd5000000, 28'sd12345678, -28'sd777777,
				28'sd2000000, -28'sd1677721}, 0, 24'h000000, 0},
			'{1, 6, 2, MODE_WEIGHTED, 0, FULL_GAIN, WORD_24,
				'{S_MAX, S_MIN, S_MAX, S_MIN, S_MAX, S_MIN}, 0, 24'h000000, 0},
			'{1, 6, 4, MODE_PLAIN, 1, UNITY_GAIN, WORD_16,
				'{28'sd3000000, -28'sd5000000, 28'sd12345678, -28'sd777777,
				28'sd2000000, -28'sd1677721}, 0, 24'h000000, 0},
			// equal counts pass through whatever the mode says, bar six with remap
			'{1, 3, 3, MODE_TOP, 0, 24'h800000, WORD_16,
				'{28'sd300000, -28'sd500000, 28'sd123456, S_MAX, S_MIN, S_ONE},
				0, 24'h000000, 0}
		};

		// Every input known from time zero; reset is asserted, then released
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = REG_SRC_CH;
		wr_data = '0;
		frame_ch.valid = 1'b0;
		frame_ch.src_sample_0 = '0;
		frame_ch.src_sample_1 = '0;
		frame_ch.src_sample_2 = '0;
		frame_ch.src_sample_3 = '0;
		frame_ch.src_sample_4 = '0;
		frame_ch.src_sample_5 = '0;
		cfg_src = 3'd2;
		cfg_out = 3'd2;
		cfg_mode = MODE_PLAIN;
		cfg_center = 1'b0;
		cfg_gain = UNITY_GAIN;
		cfg_bits = WORD_16;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (row = 0; row < NUM_ROWS; row++) begin
			wait_idle();
			if (directed_rows[row].load)
				load_config(directed_rows[row].src, directed_rows[row].out,
					directed_rows[row].mode, directed_rows[row].center,
					directed_rows[row].gain, directed_rows[row].bits);
			send_frame(directed_rows[row].lanes, directed_rows[row].typed,
				directed_rows[row].t_word, directed_rows[row].t_clamp);
			frame_ch.valid <= 1'b0;
		end

		// Random phases: a fresh register set, then a burst of frames, with idle
		// gaps outside the quiet stretch. Pairings the mixer supports dominate.
		sent = 0;
		while (sent < RANDOM_FRAMES) begin
			wait_idle();
			no_stall = (sent >= 150 && sent < 260);
			mode = 3'($urandom_range(0, 7));
			center = 1'($urandom_range(0, 1));
			case ($urandom_range(0, 9))
				0, 1: begin
					src = 3'd6;
					case ($urandom_range(0, 3))
						0: out = 3'd1;
						1: out = 3'd2;
						2: out = 3'd4;
						default: out = 3'd6;
					endcase
				end
				2: begin
					src = 3'd6;
					out = 3'd2;
					mode = MODE_WEIGHTED;
				end
				3, 4: begin
					src = 3'($urandom_range(1, 6));
					out = src;
				end
				5: begin
					src = 3'($urandom_range(1, 6));
					out = 3'd1;
				end
				6: begin
					src = 3'd6;
					out = 3'd6;
					mode = MODE_REMAP;
				end
				7: begin
					src = 3'($urandom_range(0, 7));
					out = 3'($urandom_range(0, 7));
				end
				default: begin
					src = 3'd6;
					out = $urandom_range(0, 1) ? 3'd2 : 3'd4;
				end
			endcase
			case ($urandom_range(0, 7))
				0, 1: bits = WORD_8;
				2, 3: bits = WORD_16;
				4, 5, 6: bits = WORD_24;
				default: bits = 5'($urandom_range(0, 31));
			endcase
			case ($urandom_range(0, 9))
				0, 1, 2: gain = UNITY_GAIN;
				3, 4: gain = 24'($urandom);
				5, 6, 7: gain = 24'($urandom_range(0, 131072));
				8: gain = FULL_GAIN;
				default: gain = 24'h000000;
			endcase
			load_config(src, out, mode, center, gain, bits);

			burst = $urandom_range(10, 30);
			for (k = 0; k < burst && sent < RANDOM_FRAMES; k++) begin
				for (int j = 0; j < NUM_LANES; j++)
					lanes[j] = pick_sample();
				send_frame(lanes, 1'b0, '0, 1'b0);
				sent++;
			end
			frame_ch.valid <= 1'b0;
		end

		no_stall = 1'b0;
		wait_idle();
		if (!failed)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
